### hdl/aep_pkg.sv
// Shared types, constants and the SGR ink table for the escape parser.
`default_nettype none
package aep_pkg;

    localparam int PARAM_SLOTS = 8;
    localparam int ROWS        = 25;
    localparam int COLS        = 80;

    localparam int SlotW  = $clog2(PARAM_SLOTS);
    localparam int CountW = $clog2(PARAM_SLOTS + 1);

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_CLEAR = 3'd1,
        ACT_SPAN  = 3'd2,
        ACT_FG    = 3'd3,
        ACT_BG    = 3'd4
    } act_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sgr_step;
        logic flush;
    } aep_cmd_t;

    typedef struct packed {
        logic is_sgr;
        logic sgr_stall;
        logic sgr_last;
        logic out_free;
    } aep_stat_t;

    localparam logic [1:0] CFG_FG_INK = 2'd0;
    localparam logic [1:0] CFG_BG_INK = 2'd1;

    function automatic logic [4:0] ink_lookup(input logic [3:0] idx);
        logic [4:0] r;
        case (idx)
            4'd0:    r = 5'd0;
            4'd1:    r = 5'd6;
            4'd2:    r = 5'd18;
            4'd3:    r = 5'd14;
            4'd4:    r = 5'd1;
            4'd5:    r = 5'd8;
            4'd6:    r = 5'd20;
            4'd7:    r = 5'd24;
            4'd8:    r = 5'd7;
            4'd9:    r = 5'd6;
            4'd10:   r = 5'd18;
            4'd11:   r = 5'd14;
            4'd12:   r = 5'd2;
            4'd13:   r = 5'd8;
            4'd14:   r = 5'd20;
            default: r = 5'd24;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/aep_ctrl.sv
// Sequencer for one byte: accept, execute, SGR walk, flush.
`default_nettype none
module aep_ctrl
    import aep_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire aep_stat_t stat,
    output aep_cmd_t       cmd
);

    typedef enum logic [1:0] {ST_ACCEPT, ST_EXEC, ST_SGR, ST_FLUSH} state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_ACCEPT:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.is_sgr ? ST_SGR : ST_FLUSH;
            end
            ST_SGR:
            begin
                cmd.sgr_step = 1'b1;
                if (!stat.sgr_stall && stat.sgr_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (stat.out_free)
                    state_next = ST_ACCEPT;
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCEPT;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == ST_ACCEPT);

endmodule
`default_nettype wire

### hdl/aep_dp.sv
// Parser state, parameter store, command execution and result registers.
`default_nettype none
module aep_dp
    import aep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire aep_cmd_t    cmd,
    output aep_stat_t        stat,
    input  wire logic [7:0]  in_byte,
    input  wire logic [4:0]  in_row,
    input  wire logic [6:0]  in_col,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output act_t             out_action,
    output logic [4:0]       out_span_row,
    output logic [6:0]       out_span_col,
    output logic [10:0]      out_span_count,
    output logic [4:0]       out_ink,
    output logic [4:0]       out_new_row,
    output logic [6:0]       out_new_col,
    output logic             out_last
);

    localparam logic [2:0] M_IDLE = 3'd0, M_ESC = 3'd1, M_CSI = 3'd2, M_ESC2 = 3'd3,
                           M_OSC = 3'd4, M_OSC_ESC = 3'd5;
    localparam logic [4:0] RowMax = 5'(ROWS - 1);
    localparam logic [6:0] ColMax = 7'(COLS - 1);
    localparam logic [10:0] Cols11 = 11'(COLS);

    logic [2:0]        mode_reg, mode_next;
    logic [7:0]        store_reg [PARAM_SLOTS];
    logic [CountW-1:0] pc_reg, pc_next;
    logic              dseen_reg, dseen_next;
    logic [4:0]        saved_row_reg, saved_row_next;
    logic [6:0]        saved_col_reg, saved_col_next;
    logic [4:0]        fg_reg, bg_reg;
    logic [7:0]        byte_reg;
    logic [4:0]        row_reg, nrow_reg, nrow_next;
    logic [6:0]        col_reg, ncol_reg, ncol_next;
    logic [CountW-1:0] sgr_n_reg, sgr_n_next;
    logic [SlotW-1:0]  idx_reg;
    logic              ph_reg;

    logic              pend_v_reg;
    act_t              pend_act_reg;
    logic [4:0]        pend_srow_reg;
    logic [6:0]        pend_scol_reg;
    logic [10:0]       pend_cnt_reg;
    logic [4:0]        pend_ink_reg;

    logic              out_v_reg;
    act_t              out_act_reg;
    logic [4:0]        out_srow_reg, out_ink_reg;
    logic [6:0]        out_scol_reg;
    logic [10:0]       out_cnt_reg;
    logic              out_last_reg;
    logic [4:0]        out_nrow_reg;
    logic [6:0]        out_ncol_reg;

    // execute-cycle results
    logic              ex_gen, ex_sgr, st_we;
    act_t              ex_act;
    logic [4:0]        ex_srow, ex_ink;
    logic [6:0]        ex_scol;
    logic [10:0]       ex_cnt;
    logic [SlotW-1:0]  st_addr;
    logic [7:0]        st_data, cur_par, eff0, eff1, p0, p1, n1;
    logic [CountW-1:0] pcf;
    logic [8:0]        rsum, csum;
    logic [7:0]        hrow, hcol;

    always_comb
    begin
        mode_next      = mode_reg;
        pc_next        = pc_reg;
        dseen_next     = dseen_reg;
        saved_row_next = saved_row_reg;
        saved_col_next = saved_col_reg;
        nrow_next      = row_reg;
        ncol_next      = col_reg;
        sgr_n_next     = sgr_n_reg;
        ex_gen  = 1'b0;
        ex_sgr  = 1'b0;
        ex_act  = ACT_NONE;
        ex_srow = '0;
        ex_scol = '0;
        ex_cnt  = '0;
        ex_ink  = '0;
        st_we   = 1'b0;
        st_addr = pc_reg[SlotW-1:0];
        st_data = '0;
        cur_par = store_reg[pc_reg[SlotW-1:0]];
        eff0 = (pc_reg == '0 && !dseen_reg) ? 8'd0 : store_reg[0];
        eff1 = (pc_reg == CountW'(1) && !dseen_reg) ? 8'd0 : store_reg[1];
        pcf  = ((dseen_reg || pc_reg != '0) && pc_reg < CountW'(PARAM_SLOTS))
               ? pc_reg + CountW'(1) : pc_reg;
        p0   = (pcf > CountW'(0)) ? eff0 : 8'd0;
        p1   = (pcf > CountW'(1)) ? eff1 : 8'd0;
        n1   = (p0 == 8'd0) ? 8'd1 : p0;
        rsum = {4'd0, row_reg} + {1'b0, n1};
        csum = {2'd0, col_reg} + {1'b0, n1};
        hrow = (p0 == 8'd0) ? 8'd0 : ((p0 > 8'(ROWS)) ? 8'(ROWS - 1) : p0 - 8'd1);
        hcol = (p1 == 8'd0) ? 8'd0 : ((p1 > 8'(COLS)) ? 8'(COLS - 1) : p1 - 8'd1);

        case (mode_reg)
            M_ESC:
            begin
                if (byte_reg == 8'h5B)
                begin
                    // clear slot zero so an empty first parameter reads as zero
                    mode_next = M_CSI;
                    pc_next = '0;
                    dseen_next = 1'b0;
                    st_we = 1'b1;
                    st_addr = '0;
                end
                else if (byte_reg == 8'h63)
                begin
                    ex_gen = 1'b1;
                    ex_act = ACT_CLEAR;
                    mode_next = M_IDLE;
                    pc_next = '0;
                    dseen_next = 1'b0;
                end
                else if (byte_reg == 8'h5D)
                    mode_next = M_OSC;
                else if (byte_reg >= 8'h20 && byte_reg <= 8'h2F)
                    mode_next = M_ESC2;
                else
                begin
                    mode_next = M_IDLE;
                    pc_next = '0;
                    dseen_next = 1'b0;
                end
            end
            M_ESC2:
            begin
                mode_next = M_IDLE;
                pc_next = '0;
                dseen_next = 1'b0;
            end
            M_OSC:
            begin
                if (byte_reg == 8'd7)
                begin
                    mode_next = M_IDLE;
                    pc_next = '0;
                    dseen_next = 1'b0;
                end
                else if (byte_reg == 8'd27)
                    mode_next = M_OSC_ESC;
            end
            M_OSC_ESC:
            begin
                if (byte_reg == 8'h5C)
                begin
                    mode_next = M_IDLE;
                    pc_next = '0;
                    dseen_next = 1'b0;
                end
                else
                    mode_next = M_OSC;
            end
            M_CSI:
            begin
                if (byte_reg >= 8'h30 && byte_reg <= 8'h39)
                begin
                    st_we = (pc_reg < CountW'(PARAM_SLOTS));
                    st_data = dseen_reg ? ((cur_par << 3) + (cur_par << 1) + (byte_reg - 8'h30))
                                        : (byte_reg - 8'h30);
                    dseen_next = 1'b1;
                end
                else if (byte_reg == 8'h3B)
                begin
                    // zero the new slot; an empty slot left behind already holds zero
                    if (pc_reg < CountW'(PARAM_SLOTS - 1))
                    begin
                        pc_next = pc_reg + CountW'(1);
                        st_addr = SlotW'(pc_reg + CountW'(1));
                        st_we = 1'b1;
                    end
                    else
                        st_we = (pc_reg < CountW'(PARAM_SLOTS));
                    dseen_next = 1'b0;
                end
                else if (byte_reg == 8'h3F || byte_reg == 8'h3E || byte_reg == 8'h3C)
                begin
                    mode_next = M_CSI;
                end
                else if (byte_reg >= 8'h40 && byte_reg <= 8'h7E)
                begin
                    st_we = !dseen_reg && (pc_reg < CountW'(PARAM_SLOTS));
                    mode_next = M_IDLE;
                    pc_next = '0;
                    dseen_next = 1'b0;
                    case (byte_reg)
                        8'h41: nrow_next = ({3'd0, row_reg} >= n1) ? row_reg - 5'(n1) : 5'd0;
                        8'h42: nrow_next = (rsum > {4'd0, RowMax}) ? RowMax : 5'(rsum);
                        8'h43: ncol_next = (csum > {2'd0, ColMax}) ? ColMax : 7'(csum);
                        8'h44: ncol_next = ({1'b0, col_reg} >= n1) ? col_reg - 7'(n1) : 7'd0;
                        8'h48, 8'h66:
                        begin
                            nrow_next = 5'(hrow);
                            ncol_next = 7'(hcol);
                        end
                        8'h4A:
                        begin
                            if (p0 == 8'd2)
                            begin
                                ex_gen = 1'b1;
                                ex_act = ACT_CLEAR;
                            end
                            else if (p0 == 8'd0)
                            begin
                                ex_gen  = 1'b1;
                                ex_act  = ACT_SPAN;
                                ex_srow = row_reg;
                                ex_scol = col_reg;
                                ex_cnt  = (Cols11 - {4'd0, col_reg})
                                        + 11'({6'd0, RowMax - row_reg} * Cols11);
                            end
                        end
                        8'h4B:
                        begin
                            ex_gen  = 1'b1;
                            ex_act  = ACT_SPAN;
                            ex_srow = row_reg;
                            if (p0 == 8'd2)
                                ex_cnt = Cols11;
                            else if (p0 == 8'd0)
                            begin
                                ex_scol = col_reg;
                                ex_cnt  = Cols11 - {4'd0, col_reg};
                            end
                            else
                                ex_cnt = {4'd0, col_reg} + 11'd1;
                        end
                        8'h6D:
                        begin
                            ex_sgr = 1'b1;
                            sgr_n_next = pcf;
                        end
                        8'h73:
                        begin
                            saved_row_next = row_reg;
                            saved_col_next = col_reg;
                        end
                        8'h75:
                        begin
                            nrow_next = saved_row_reg;
                            ncol_next = saved_col_reg;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    mode_next = M_IDLE;
                    pc_next = '0;
                    dseen_next = 1'b0;
                end
            end
            default:
            begin
                if (byte_reg == 8'd27)
                    mode_next = M_ESC;
                else if (byte_reg == 8'h9B)
                begin
                    mode_next = M_CSI;
                    pc_next = '0;
                    dseen_next = 1'b0;
                    st_we = 1'b1;
                    st_addr = '0;
                end
                else
                    mode_next = M_IDLE;
            end
        endcase
    end

    // SGR walk: one parameter phase per cycle while the output register is not stalled
    logic [7:0]  sv;
    logic        s_gen, s_done, out_free, push;
    act_t        s_act;
    logic [4:0]  s_ink;
    logic [CountW-1:0] n_eff;

    always_comb
    begin
        sv     = (sgr_n_reg == '0) ? 8'd0 : store_reg[idx_reg];
        s_gen  = 1'b1;
        s_done = 1'b1;
        s_act  = ACT_FG;
        s_ink  = '0;
        if (sv == 8'd0)
        begin
            s_act  = ph_reg ? ACT_BG : ACT_FG;
            s_ink  = ph_reg ? bg_reg : fg_reg;
            s_done = ph_reg;
        end
        else if (sv >= 8'd30 && sv <= 8'd37)
            s_ink = ink_lookup(4'(sv - 8'd30));
        else if (sv >= 8'd40 && sv <= 8'd47)
        begin
            s_act = ACT_BG;
            s_ink = ink_lookup(4'(sv - 8'd40));
        end
        else if (sv >= 8'd90 && sv <= 8'd97)
            s_ink = ink_lookup(4'(sv - 8'd82));
        else if (sv >= 8'd100 && sv <= 8'd107)
        begin
            s_act = ACT_BG;
            s_ink = ink_lookup(4'(sv - 8'd92));
        end
        else
            s_gen = 1'b0;
    end

    assign n_eff    = (sgr_n_reg == '0) ? CountW'(1) : sgr_n_reg;
    assign out_free = !out_v_reg || out_ready;

    assign stat.is_sgr    = ex_sgr;
    assign stat.sgr_stall = s_gen && pend_v_reg && !out_free;
    assign stat.sgr_last  = s_done && ((CountW'(idx_reg) + CountW'(1)) >= n_eff);
    assign stat.out_free  = out_free;

    assign push = (cmd.sgr_step && !stat.sgr_stall && s_gen && pend_v_reg)
               || (cmd.flush && out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            pc_reg        <= '0;
            dseen_reg     <= 1'b0;
            saved_row_reg <= '0;
            saved_col_reg <= '0;
            fg_reg        <= 5'd18;
            bg_reg        <= 5'd0;
            pend_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
            idx_reg       <= '0;
            ph_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_FG_INK)
                fg_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_BG_INK)
                bg_reg <= cfg_data;
            if (cmd.exec)
            begin
                mode_reg      <= mode_next;
                pc_reg        <= pc_next;
                dseen_reg     <= dseen_next;
                saved_row_reg <= saved_row_next;
                saved_col_reg <= saved_col_next;
                pend_v_reg    <= ex_gen;
                idx_reg       <= '0;
                ph_reg        <= 1'b0;
            end
            if (cmd.sgr_step && !stat.sgr_stall)
            begin
                if (s_gen)
                    pend_v_reg <= 1'b1;
                if (s_done)
                begin
                    ph_reg  <= 1'b0;
                    idx_reg <= idx_reg + SlotW'(1);
                end
                else
                    ph_reg <= 1'b1;
            end
            if (cmd.flush && out_free)
                pend_v_reg <= 1'b0;
            if (push)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
            row_reg  <= (in_row > RowMax) ? RowMax : in_row;
            col_reg  <= (in_col > ColMax) ? ColMax : in_col;
        end
        if (cmd.exec)
        begin
            if (st_we)
                store_reg[st_addr] <= st_data;
            nrow_reg      <= nrow_next;
            ncol_reg      <= ncol_next;
            sgr_n_reg     <= sgr_n_next;
            pend_act_reg  <= ex_act;
            pend_srow_reg <= ex_srow;
            pend_scol_reg <= ex_scol;
            pend_cnt_reg  <= ex_cnt;
            pend_ink_reg  <= ex_ink;
        end
        if (cmd.sgr_step && !stat.sgr_stall && s_gen)
        begin
            pend_act_reg  <= s_act;
            pend_srow_reg <= '0;
            pend_scol_reg <= '0;
            pend_cnt_reg  <= '0;
            pend_ink_reg  <= s_ink;
        end
        if (push)
        begin
            out_act_reg  <= pend_v_reg ? pend_act_reg : ACT_NONE;
            out_srow_reg <= pend_v_reg ? pend_srow_reg : 5'd0;
            out_scol_reg <= pend_v_reg ? pend_scol_reg : 7'd0;
            out_cnt_reg  <= pend_v_reg ? pend_cnt_reg : 11'd0;
            out_ink_reg  <= pend_v_reg ? pend_ink_reg : 5'd0;
            out_nrow_reg <= nrow_reg;
            out_ncol_reg <= ncol_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid      = out_v_reg;
    assign out_action     = out_act_reg;
    assign out_span_row   = out_srow_reg;
    assign out_span_col   = out_scol_reg;
    assign out_span_count = out_cnt_reg;
    assign out_ink        = out_ink_reg;
    assign out_new_row    = out_nrow_reg;
    assign out_new_col    = out_ncol_reg;
    assign out_last       = out_last_reg;

endmodule
`default_nettype wire

### hdl/ansi_escape_parser.sv
// Top level of the ANSI / VT100 escape sequence parser.
//
// Input stream (s_*): one terminal byte per beat together with the cursor
// kept by the screen logic. Output stream (m_*): one or more result beats per
// input beat; m_tlast marks the final result of that byte. m_tuser carries the
// action code. The configuration port writes the default SGR inks; the user
// must write them only while idle; the block itself does not enforce this.
//
// Each byte is accepted, its command executed and its final result flushed.
// An SGR byte walks its parameters through a single shared step, one parameter
// per cycle unless the output stalls, a reset parameter taking a second step.
// The next byte is accepted while the last result still waits in the output
// register. When the receiver stalls, the walk holds its pending result until
// the output register frees. Reset returns the parser to idle, clears the
// saved cursor and restores the default inks (fg 18, bg 0); the parameter
// store is not cleared and is always written before it is read.
`default_nettype none
module ansi_escape_parser
    import aep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // in_byte[7:0], cur_row[12:8], cur_col[19:13]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // span_row, span_col, span_count, ink, new_row, new_col
    output logic [2:0]       m_tuser,   // action
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    aep_cmd_t    cmd;
    aep_stat_t   stat;
    act_t        action;
    logic [4:0]  span_row, ink, new_row;
    logic [6:0]  span_col, new_col;
    logic [10:0] span_count;

    aep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    aep_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_byte        (s_tdata[7:0]),
        .in_row         (s_tdata[12:8]),
        .in_col         (s_tdata[19:13]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_action     (action),
        .out_span_row   (span_row),
        .out_span_col   (span_col),
        .out_span_count (span_count),
        .out_ink        (ink),
        .out_new_row    (new_row),
        .out_new_col    (new_col),
        .out_last       (m_tlast)
    );

    assign m_tuser = action;
    assign m_tdata = {new_col, new_row, ink, span_count, span_col, span_row};

    // one byte at a time: no second accept straight after the first
    a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("byte accepted while previous still executing");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (new_row < 5'(ROWS)) && (new_col < 7'(COLS)))
        else $error("cursor outside screen");

    a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (action != ACT_SPAN) |-> span_count == 11'd0 && span_row == 5'd0)
        else $error("span fields set on non-span result");

endmodule
`default_nettype wire
